/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Each macro takes a label, a clock, an active-low reset, an antecedent, a consequent and a
// message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mscd_pkg.sv */
// Package for the music sequence command decoder.
// Holds opcode constants, parser phase codes and the record types passed between stages.
package mscd_pkg;

  localparam logic [14:0] LEN_MAX = 15'h7FFF;

  // Record header bytes.
  localparam logic [7:0] NOTE_REC = 8'h90;
  localparam logic [7:0] REST_REC = 8'h80;

  // Note opcode ranges.
  localparam logic [7:0] OP_T8_FIRST  = 8'h00;
  localparam logic [7:0] OP_T8_LAST   = 8'h0C;
  localparam logic [7:0] OP_T16_FIRST = 8'h0D;
  localparam logic [7:0] OP_T16_LAST  = 8'h19;
  localparam logic [7:0] OP_DEF_FIRST = 8'h80;
  localparam logic [7:0] OP_DEF_LAST  = 8'h8C;

  // Commands.
  localparam logic [7:0] OP_GABS     = 8'hEA;
  localparam logic [7:0] OP_MUTE     = 8'hEC;
  localparam logic [7:0] OP_OCT_UP   = 8'hEE;
  localparam logic [7:0] OP_OCT_DN   = 8'hEF;
  localparam logic [7:0] OP_OCTB     = 8'hF0;
  localparam logic [7:0] OP_OCTN     = 8'hF1;
  localparam logic [7:0] OP_GREL     = 8'hF2;
  localparam logic [7:0] OP_LEN      = 8'hF3;
  localparam logic [7:0] OP_SKIP2    = 8'hF6;
  localparam logic [7:0] OP_NOCT_DN  = 8'hF7;
  localparam logic [7:0] OP_NOCT_UP  = 8'hF8;
  localparam logic [7:0] OP_SKIP1_A  = 8'hFA;
  localparam logic [7:0] OP_SKIP1_B  = 8'hFD;
  localparam logic [7:0] OP_SKIP3    = 8'hFE;
  localparam logic [7:0] OP_END      = 8'hFF;
  localparam logic [7:0] OP_PASS1_A  = 8'hE0;
  localparam logic [7:0] OP_PASS1_B  = 8'hE1;
  localparam logic [7:0] OP_PASS1_C  = 8'hF4;
  localparam logic [7:0] OP_PASS1_D  = 8'hF5;
  localparam logic [7:0] OP_PASS1_E  = 8'hF9;
  localparam logic [7:0] OP_PASS1_F  = 8'hFC;
  localparam logic [7:0] OP_PASS1_G  = 8'hE5;
  localparam logic [7:0] OP_PASS1_H  = 8'hEB;
  localparam logic [7:0] OP_PASS0    = 8'hE9;
  localparam logic [7:0] OP_PASS8_A  = 8'hE6;
  localparam logic [7:0] OP_PASS8_B  = 8'hE7;
  localparam logic [7:0] OP_PASS10   = 8'hE8;
  localparam logic [7:0] OP_PASS3    = 8'hE4;

  // Result queue between the gate stage and the output side.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [11:0] {
    PH_OP    = 12'b0000_0000_0001,
    PH_T8    = 12'b0000_0000_0010,
    PH_T16LO = 12'b0000_0000_0100,
    PH_T16HI = 12'b0000_0000_1000,
    PH_OCTB  = 12'b0000_0001_0000,
    PH_OCTN  = 12'b0000_0010_0000,
    PH_GREL  = 12'b0000_0100_0000,
    PH_GABS  = 12'b0000_1000_0000,
    PH_LEN1  = 12'b0001_0000_0000,
    PH_LEN2  = 12'b0010_0000_0000,
    PH_SKIP  = 12'b0100_0000_0000,
    PH_PASS  = 12'b1000_0000_0000
  } phase_t;

  // Channel state as reported with every result.
  typedef struct packed {
    logic        mute;
    logic [31:0] total_time;
    logic [14:0] loop_pos;
    logic [31:0] loop_total;
    logic [14:0] out_len;
    logic        overflow;
  } status_t;

  // Classified item from the front stage.
  typedef struct packed {
    logic        kind;
    logic [2:0]  n;
    logic        is_note;
    logic        is_rest;
    logic [7:0]  pitch;
    logic [15:0] t;
    logic [12:0] q;
    logic [8:0]  g;
    logic        gabs;
    logic [7:0]  byte0;
    status_t     st;
  } rec_t;

  // One queued step: up to six bytes sharing a status snapshot.
  typedef struct packed {
    logic            kind;
    logic [2:0]      n;
    logic [5:0][7:0] bytes;
    status_t         st;
  } qent_t;

endpackage

/* rtl/core/music_sequence_command_decoder_top.sv */
// Music sequence command decoder for one channel. The front stage takes one input byte per
// cycle while not stalled, updates the parser and channel state and classifies the byte; the
// gate stage registers the record and multiplies out note on/off times; a four-entry queue
// then feeds the output side, which sends one result per cycle unless out_stall holds it. A
// stream byte thus enters every cycle while the queue has room. Sustained rate is set by the
// output side: a note step gives it six results, a rest three, a pass-through byte or
// summary one, and steps without results none.
// Depends on mscd_pkg, mscd_front, mscd_gate, mscd_queue and mscd_back.
module music_sequence_command_decoder_top import mscd_pkg::*; #(
  parameter int OUT_BUFFER_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_loop_block_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_mute,
  output logic [31:0] out_total_time,
  output logic [14:0] out_loop_start_position,
  output logic [31:0] out_loop_start_total,
  output logic [14:0] out_output_length,
  output logic        out_overflow
);

  logic  a_valid;
  rec_t  a_rec;
  logic  b_ready;
  logic  q_ready;
  logic  push;
  qent_t ent;
  logic  pop;
  logic  head_valid;
  qent_t head;

  mscd_front #(
    .OUT_BUFFER_BYTES(OUT_BUFFER_BYTES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_stream_byte     (in_stream_byte),
    .in_loop_block_start(in_loop_block_start),
    .b_ready            (b_ready),
    .a_valid            (a_valid),
    .a_rec              (a_rec)
  );

  mscd_gate u_gate (
    .clk    (clk),
    .rst_n  (rst_n),
    .a_valid(a_valid),
    .a_rec  (a_rec),
    .b_ready(b_ready),
    .q_ready(q_ready),
    .push   (push),
    .ent    (ent)
  );

  mscd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ent  (ent),
    .q_ready   (q_ready),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  mscd_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head_valid             (head_valid),
    .head                   (head),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_kind               (out_kind),
    .out_byte               (out_byte),
    .out_last_of_run        (out_last_of_run),
    .out_mute               (out_mute),
    .out_total_time         (out_total_time),
    .out_loop_start_position(out_loop_start_position),
    .out_loop_start_total   (out_loop_start_total),
    .out_output_length      (out_output_length),
    .out_overflow           (out_overflow)
  );

endmodule

/* rtl/core/mscd_front.sv */
// Front stage: parses the command byte stream, keeps the channel state and classifies
// each item into a record. Depends on mscd_pkg.
module mscd_front import mscd_pkg::*; #(
  parameter int OUT_BUFFER_BYTES = 32768
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_stream_byte,
  input  logic       in_loop_block_start,
  input  logic       b_ready,
  output logic       a_valid,
  output rec_t       a_rec
);

  localparam int CAP = (OUT_BUFFER_BYTES < int'(LEN_MAX)) ? OUT_BUFFER_BYTES : int'(LEN_MAX);
  localparam logic [15:0] CAP16 = 16'(CAP);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cur_op_r, cur_op_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [7:0]  base_r, base_nxt;
  logic [7:0]  noct_r, noct_nxt;
  logic [14:0] dlen_r, dlen_nxt;
  logic [8:0]  gamt_r, gamt_nxt;
  logic        gabs_r, gabs_nxt;
  logic [31:0] tacc_r, tacc_nxt;
  logic [14:0] cnt_r, cnt_nxt;
  logic [14:0] lpos_r, lpos_nxt;
  logic [31:0] ltime_r, ltime_nxt;
  logic        mute_r, mute_nxt;
  logic        ovf_r, ovf_nxt;
  logic        a_valid_r, a_valid_nxt;
  rec_t        a_rec_r, a_rec_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        note_go;
  logic [7:0]  nt;
  logic [15:0] t;
  logic        rest;
  logic [2:0]  emit_n;
  logic [7:0]  byte0;
  logic [3:0]  rem_dec;
  logic [15:0] sum16;

  assign in_stall = a_valid_r && !b_ready;
  assign accept   = in_valid && !in_stall;
  assign b        = in_stream_byte;
  assign a_valid  = a_valid_r;
  assign a_rec    = a_rec_r;

  always_comb begin
    phase_nxt = phase_r;
    cur_op_nxt = cur_op_r;
    hold_nxt = hold_r;
    rem_nxt = rem_r;
    base_nxt = base_r;
    noct_nxt = noct_r;
    dlen_nxt = dlen_r;
    gamt_nxt = gamt_r;
    gabs_nxt = gabs_r;
    tacc_nxt = tacc_r;
    cnt_nxt = cnt_r;
    lpos_nxt = lpos_r;
    ltime_nxt = ltime_r;
    mute_nxt = mute_r;
    ovf_nxt = ovf_r;
    note_go = 1'b0;
    nt = 8'h00;
    t = 16'h0000;
    emit_n = 3'd0;
    byte0 = 8'h00;
    rem_dec = (rem_r != 4'd0) ? rem_r - 4'd1 : 4'd0;

    if (accept && !in_command) begin
      // The loop mark sees the state from before this byte.
      if (in_loop_block_start) begin
        lpos_nxt = cnt_r;
        ltime_nxt = tacc_r;
      end
      unique case (phase_r)
        PH_T8: begin
          phase_nxt = PH_OP;
          note_go = 1'b1;
          nt = cur_op_r;
          t = {8'h00, b};
        end
        PH_T16LO: begin
          hold_nxt = b;
          phase_nxt = PH_T16HI;
        end
        PH_T16HI: begin
          phase_nxt = PH_OP;
          note_go = 1'b1;
          nt = cur_op_r - OP_T16_FIRST;
          t = {b, hold_r};
        end
        PH_OCTB: begin
          base_nxt = b;
          noct_nxt = b;
          phase_nxt = PH_OP;
        end
        PH_OCTN: begin
          noct_nxt = b;
          phase_nxt = PH_OP;
        end
        PH_GREL: begin
          gabs_nxt = 1'b0;
          gamt_nxt = {1'b0, b} + 9'd1;
          phase_nxt = PH_OP;
        end
        PH_GABS: begin
          gabs_nxt = 1'b1;
          gamt_nxt = {1'b0, b};
          phase_nxt = PH_OP;
        end
        PH_LEN1: begin
          if (b[7]) begin
            hold_nxt = b;
            phase_nxt = PH_LEN2;
          end else begin
            dlen_nxt = {7'h00, b};
            phase_nxt = PH_OP;
          end
        end
        PH_LEN2: begin
          dlen_nxt = {hold_r[6:0], b};
          phase_nxt = PH_OP;
        end
        PH_SKIP, PH_PASS: begin
          if (phase_r == PH_PASS) begin
            emit_n = 3'd1;
            byte0 = b;
          end
          rem_nxt = rem_dec;
          if (rem_dec == 4'd0) begin
            phase_nxt = PH_OP;
          end
        end
        default: begin
          phase_nxt = PH_OP;
          if (b != OP_END) begin
            cur_op_nxt = b;
          end
          unique case (b) inside
            [OP_T8_FIRST:OP_T8_LAST]:   phase_nxt = PH_T8;
            [OP_T16_FIRST:OP_T16_LAST]: phase_nxt = PH_T16LO;
            [OP_DEF_FIRST:OP_DEF_LAST]: begin
              note_go = 1'b1;
              nt = {1'b0, b[6:0]};
              t = {1'b0, dlen_r};
            end
            OP_OCT_UP: begin
              base_nxt = {5'h00, base_r[2:0] + 3'd1};
              noct_nxt = {5'h00, base_r[2:0] + 3'd1};
            end
            OP_OCT_DN: begin
              base_nxt = {5'h00, base_r[2:0] - 3'd1};
              noct_nxt = {5'h00, base_r[2:0] - 3'd1};
            end
            OP_OCTB:    phase_nxt = PH_OCTB;
            OP_OCTN:    phase_nxt = PH_OCTN;
            OP_GREL:    phase_nxt = PH_GREL;
            OP_GABS:    phase_nxt = PH_GABS;
            OP_LEN:     phase_nxt = PH_LEN1;
            OP_NOCT_DN: noct_nxt = {5'h00, noct_r[2:0] - 3'd1};
            OP_NOCT_UP: noct_nxt = {5'h00, noct_r[2:0] + 3'd1};
            OP_SKIP2: begin
              phase_nxt = PH_SKIP;
              rem_nxt = 4'd2;
            end
            OP_SKIP1_A, OP_SKIP1_B: begin
              phase_nxt = PH_SKIP;
              rem_nxt = 4'd1;
            end
            OP_SKIP3: begin
              phase_nxt = PH_SKIP;
              rem_nxt = 4'd3;
            end
            OP_PASS1_A, OP_PASS1_B, OP_PASS1_C, OP_PASS1_D,
            OP_PASS1_E, OP_PASS1_F, OP_PASS1_G, OP_PASS1_H: begin
              emit_n = 3'd1;
              byte0 = b;
              phase_nxt = PH_PASS;
              rem_nxt = 4'd1;
            end
            OP_PASS0: begin
              emit_n = 3'd1;
              byte0 = b;
            end
            OP_PASS8_A, OP_PASS8_B: begin
              emit_n = 3'd1;
              byte0 = b;
              phase_nxt = PH_PASS;
              rem_nxt = 4'd8;
            end
            OP_PASS10: begin
              emit_n = 3'd1;
              byte0 = b;
              phase_nxt = PH_PASS;
              rem_nxt = 4'd10;
            end
            OP_PASS3: begin
              emit_n = 3'd1;
              byte0 = b;
              phase_nxt = PH_PASS;
              rem_nxt = 4'd3;
            end
            OP_MUTE: begin
              mute_nxt = 1'b1;
              note_go = 1'b1;
            end
            default: ;
          endcase
        end
      endcase
    end

    // With an absolute gate, on time is zero exactly when the time equals the amount.
    rest = (nt == 8'h00) || (gabs_r && (t != 16'd1) && (t == {7'h00, gamt_r}));
    if (note_go) begin
      emit_n = rest ? 3'd3 : 3'd6;
      tacc_nxt = tacc_r + {{16{t[15]}}, t};
      noct_nxt = base_r;
    end

    sum16 = {1'b0, cnt_r} + {13'h0000, emit_n};
    if (sum16 > CAP16) begin
      cnt_nxt = CAP16[14:0];
      ovf_nxt = 1'b1;
    end else begin
      cnt_nxt = sum16[14:0];
    end
    if (!accept || in_command) begin
      cnt_nxt = cnt_r;
      ovf_nxt = ovf_r;
    end

    a_rec_nxt.kind = in_command;
    a_rec_nxt.n = in_command ? 3'd1 : emit_n;
    a_rec_nxt.is_note = note_go;
    a_rec_nxt.is_rest = rest;
    a_rec_nxt.pitch = {noct_r[4:0], 3'b000} + {noct_r[5:0], 2'b00} + nt - 8'd1;
    a_rec_nxt.t = t;
    // Time divided by eight and rounded toward minus infinity, ready for the gate multiply.
    a_rec_nxt.q = t[15:3];
    a_rec_nxt.g = gamt_r;
    a_rec_nxt.gabs = gabs_r;
    a_rec_nxt.byte0 = in_command ? 8'h00 : byte0;
    a_rec_nxt.st.mute = mute_nxt;
    a_rec_nxt.st.total_time = tacc_nxt;
    a_rec_nxt.st.loop_pos = lpos_nxt;
    a_rec_nxt.st.loop_total = ltime_nxt;
    a_rec_nxt.st.out_len = cnt_nxt;
    a_rec_nxt.st.overflow = ovf_nxt;

    a_valid_nxt = a_valid_r && !b_ready;
    if (accept && (in_command || emit_n != 3'd0)) begin
      a_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OP;
      cur_op_r <= 8'h00;
      hold_r <= 8'h00;
      rem_r <= 4'd0;
      base_r <= 8'd4;
      noct_r <= 8'd4;
      dlen_r <= 15'd64;
      gamt_r <= 9'd7;
      gabs_r <= 1'b0;
      tacc_r <= 32'd0;
      cnt_r <= 15'd0;
      lpos_r <= 15'd0;
      ltime_r <= 32'd0;
      mute_r <= 1'b0;
      ovf_r <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cur_op_r <= cur_op_nxt;
      hold_r <= hold_nxt;
      rem_r <= rem_nxt;
      base_r <= base_nxt;
      noct_r <= noct_nxt;
      dlen_r <= dlen_nxt;
      gamt_r <= gamt_nxt;
      gabs_r <= gabs_nxt;
      tacc_r <= tacc_nxt;
      cnt_r <= cnt_nxt;
      lpos_r <= lpos_nxt;
      ltime_r <= ltime_nxt;
      mute_r <= mute_nxt;
      ovf_r <= ovf_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_rec_r <= a_rec_nxt;
    end
  end

endmodule

/* rtl/core/mscd_gate.sv */
// Gate stage: multiplies out note gate times, formats note and rest records and passes
// other bytes through. Depends on mscd_pkg; sits between mscd_front and mscd_queue.
module mscd_gate import mscd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  a_valid,
  input  rec_t  a_rec,
  output logic  b_ready,
  input  logic  q_ready,
  output logic  push,
  output qent_t ent
);

  logic               b_valid_r;
  rec_t               b_rec_r;
  logic [15:0]        b_prod_r;
  logic signed [22:0] prod_full;
  logic [15:0]        t;
  logic [15:0]        p;
  logic [15:0]        d;
  logic [15:0]        on;
  logic [15:0]        off;

  assign b_ready   = !b_valid_r || q_ready;
  assign push      = b_valid_r && q_ready;
  assign prod_full = $signed(a_rec.q) * $signed({1'b0, a_rec.g});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_rec_r <= a_rec;
      b_prod_r <= prod_full[15:0];
    end
  end

  always_comb begin
    t = b_rec_r.t;
    p = (b_prod_r == 16'd0) ? 16'd1 : b_prod_r;
    if (t == p) begin
      p = p - 16'd1;
    end
    d = t - {7'h00, b_rec_r.g};
    if (t == 16'd1) begin
      on = 16'd1;
    end else if (!b_rec_r.gabs) begin
      on = (b_rec_r.g == 9'd8) ? t - 16'd1 : p;
    end else begin
      on = d[15] ? 16'd1 : d;
    end
    off = t - on;

    ent.kind = b_rec_r.kind;
    ent.n = b_rec_r.n;
    ent.st = b_rec_r.st;
    ent.bytes = '0;
    if (b_rec_r.is_note && b_rec_r.is_rest) begin
      ent.bytes[0] = REST_REC;
      ent.bytes[1] = t[7:0];
      ent.bytes[2] = t[15:8];
    end else if (b_rec_r.is_note) begin
      ent.bytes[0] = NOTE_REC;
      ent.bytes[1] = b_rec_r.pitch;
      ent.bytes[2] = on[7:0];
      ent.bytes[3] = on[15:8];
      ent.bytes[4] = off[7:0];
      ent.bytes[5] = off[15:8];
    end else begin
      ent.bytes[0] = b_rec_r.byte0;
    end
  end

endmodule

/* rtl/core/mscd_queue.sv */
// Short queue of formatted steps between the gate stage and the output side.
// Depends on mscd_pkg.
module mscd_queue import mscd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  q_ready,
  input  logic  pop,
  output logic  head_valid,
  output qent_t head
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign q_ready    = (cnt_r != QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && q_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

/* rtl/core/mscd_back.sv */
// Output side: walks the bytes of the queue head, one result per transfer.
// Depends on mscd_pkg; reads from mscd_queue.
module mscd_back import mscd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  qent_t       head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_mute,
  output logic [31:0] out_total_time,
  output logic [14:0] out_loop_start_position,
  output logic [31:0] out_loop_start_total,
  output logic [14:0] out_output_length,
  output logic        out_overflow
);

  logic [2:0] k_r;
  logic       xfer;

  assign out_valid               = head_valid;
  assign xfer                    = head_valid && !out_stall;
  assign out_kind                = head.kind;
  assign out_byte                = head.bytes[k_r];
  assign out_last_of_run         = (k_r == head.n - 3'd1);
  assign out_mute                = head.st.mute;
  assign out_total_time          = head.st.total_time;
  assign out_loop_start_position = head.st.loop_pos;
  assign out_loop_start_total    = head.st.loop_total;
  assign out_output_length       = head.st.out_len;
  assign out_overflow            = head.st.overflow;
  assign pop                     = xfer && out_last_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 3'd0;
    end else if (xfer) begin
      k_r <= out_last_of_run ? 3'd0 : k_r + 3'd1;
    end
  end

endmodule

/* rtl/core/mscd_checker.sv */
// Port-level checker for the music sequence command decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mscd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic       out_overflow
);

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `CHK_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_byte), "byte changed while stalled")
  `CHK_SAME(a_sum_single, clk, rst_n, out_valid && out_kind, out_last_of_run && out_byte == 8'h00, "summary is not a single empty result")
  `CHK_NEXT(a_ovf_sticky, clk, rst_n, out_valid && !out_stall && out_overflow, !out_valid || out_overflow, "overflow flag cleared")

endmodule

bind music_sequence_command_decoder_top mscd_checker u_mscd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_byte       (out_byte),
  .out_last_of_run(out_last_of_run),
  .out_overflow   (out_overflow)
);

/* tb/music_sequence_command_decoder_top_test.sv */
// Self-checking testbench for music_sequence_command_decoder_top: drives command bytes and
// finish requests, predicts every output byte and status snapshot, and checks them in order.
// Depends on mscd_pkg and the decoder top level only.
`timescale 1ns / 1ps

import mscd_pkg::*;

localparam bit CMD_STREAM  = 1'b0;
localparam bit CMD_FINISH  = 1'b1;
localparam bit KIND_BYTE   = 1'b0;
localparam bit KIND_STATUS = 1'b1;

// One expected or observed result, fields in port order.
typedef struct packed {
  logic       kind;
  logic [7:0] data;
  logic       last;
  status_t    st;
} result_rec_t;

class record_scoreboard;
  int          failures;
  int          count_cap;
  result_rec_t expected_records[$];

  // Channel state as the decoder should hold it.
  phase_t      phase;
  bit [7:0]    cur_op;
  bit [7:0]    hold;
  bit [3:0]    remaining;
  bit [7:0]    base_oct;
  bit [7:0]    note_oct;
  bit [14:0]   def_len;
  bit [8:0]    gate_amt;
  bit          gate_abs;
  bit          muted;
  bit          overflowed;
  bit [31:0]   total;
  bit [31:0]   loop_total;
  bit [14:0]   emitted;
  bit [14:0]   loop_pos;
  bit [7:0]    step_bytes[$];

  function new(int cap);
    count_cap  = cap;
    failures   = 0;
    phase      = PH_OP;
    cur_op     = '0;
    hold       = '0;
    remaining  = '0;
    base_oct   = 8'd4;
    note_oct   = 8'd4;
    def_len    = 15'd64;
    gate_amt   = 9'd7;
    gate_abs   = 1'b0;
    muted      = 1'b0;
    overflowed = 1'b0;
    total      = '0;
    loop_total = '0;
    emitted    = '0;
    loop_pos   = '0;
  endfunction

  function int pending();
    return expected_records.size();
  endfunction

  function void emit(bit [7:0] b);
    step_bytes.push_back(b);
    if (emitted < count_cap) emitted++;
    else overflowed = 1'b1;
  endfunction

  // Builds a rest or note record; the on time follows the gate mode, all in 16-bit wrap.
  function void make_note(bit [7:0] note, bit signed [15:0] t);
    int               ti;
    int               q;
    int               g;
    bit signed [15:0] on16;
    bit signed [15:0] off16;
    ti = t;
    g  = gate_amt;
    if (t == 1) begin
      on16 = 1;
    end else if (!gate_abs) begin
      if (g == 8) begin
        on16 = 16'(ti - 1);
      end else begin
        // Division by eight rounds toward minus infinity for negative times.
        q = (ti >= 0) ? (ti >>> 3) : -(((-ti) + 7) >>> 3);
        on16 = 16'(q * g);
        if (on16 == 0) on16 = 1;
        if (t == on16) on16 = 16'(int'(on16) - 1);
      end
    end else begin
      on16 = 16'(ti - g);
      if (on16 < 0) on16 = 1;
    end
    off16 = 16'(ti - int'(on16));
    if (note == 0 || on16 == 0) begin
      emit(REST_REC);
      emit(t[7:0]);
      emit(t[15:8]);
    end else begin
      emit(NOTE_REC);
      emit(8'(int'(note_oct) * 12 + int'(note) - 1));
      emit(on16[7:0]);
      emit(on16[15:8]);
      emit(off16[7:0]);
      emit(off16[15:8]);
    end
    total    = total + 32'(ti);
    note_oct = base_oct;
  endfunction

  function void decode_opcode(bit [7:0] b);
    cur_op = b;
    if (b <= OP_T8_LAST) begin
      phase = PH_T8;
    end else if (b <= OP_T16_LAST) begin
      phase = PH_T16LO;
    end else if (b >= OP_DEF_FIRST && b <= OP_DEF_LAST) begin
      make_note(b & 8'h7F, {1'b0, def_len});
    end else begin
      case (b)
        OP_OCT_UP: begin
          base_oct = 8'((base_oct + 1) & 7);
          note_oct = base_oct;
        end
        OP_OCT_DN: begin
          base_oct = 8'((base_oct + 7) & 7);
          note_oct = base_oct;
        end
        OP_OCTB: phase = PH_OCTB;
        OP_OCTN: phase = PH_OCTN;
        OP_GREL: phase = PH_GREL;
        OP_GABS: phase = PH_GABS;
        OP_LEN: phase = PH_LEN1;
        OP_NOCT_DN: note_oct = 8'((note_oct + 7) & 7);
        OP_NOCT_UP: note_oct = 8'((note_oct + 1) & 7);
        OP_SKIP2: begin
          phase = PH_SKIP;
          remaining = 2;
        end
        OP_SKIP1_A, OP_SKIP1_B: begin
          phase = PH_SKIP;
          remaining = 1;
        end
        OP_SKIP3: begin
          phase = PH_SKIP;
          remaining = 3;
        end
        OP_PASS1_A, OP_PASS1_B, OP_PASS1_C, OP_PASS1_D,
        OP_PASS1_E, OP_PASS1_F, OP_PASS1_G, OP_PASS1_H: begin
          emit(b);
          phase = PH_PASS;
          remaining = 1;
        end
        OP_PASS0: emit(b);
        OP_PASS8_A, OP_PASS8_B: begin
          emit(b);
          phase = PH_PASS;
          remaining = 8;
        end
        OP_PASS10: begin
          emit(b);
          phase = PH_PASS;
          remaining = 10;
        end
        OP_PASS3: begin
          emit(b);
          phase = PH_PASS;
          remaining = 3;
        end
        OP_MUTE: begin
          muted = 1'b1;
          make_note(8'd0, 16'sd0);
        end
        default: ;
      endcase
    end
  endfunction

  function void decode_byte(bit [7:0] b);
    case (phase)
      PH_T8: begin
        phase = PH_OP;
        make_note(cur_op, {8'h00, b});
      end
      PH_T16LO: begin
        hold  = b;
        phase = PH_T16HI;
      end
      PH_T16HI: begin
        phase = PH_OP;
        make_note(cur_op - OP_T16_FIRST, {b, hold});
      end
      PH_OCTB: begin
        base_oct = b;
        note_oct = b;
        phase    = PH_OP;
      end
      PH_OCTN: begin
        note_oct = b;
        phase    = PH_OP;
      end
      PH_GREL: begin
        gate_abs = 1'b0;
        gate_amt = 9'(b) + 9'd1;
        phase    = PH_OP;
      end
      PH_GABS: begin
        gate_abs = 1'b1;
        gate_amt = 9'(b);
        phase    = PH_OP;
      end
      PH_LEN1: begin
        if (b[7]) begin
          hold  = b;
          phase = PH_LEN2;
        end else begin
          def_len = 15'(b);
          phase   = PH_OP;
        end
      end
      PH_LEN2: begin
        def_len = {hold[6:0], b};
        phase   = PH_OP;
      end
      PH_SKIP, PH_PASS: begin
        if (phase == PH_PASS) emit(b);
        if (remaining > 0) remaining--;
        if (remaining == 0) phase = PH_OP;
      end
      default: begin
        // A block end at opcode position produces nothing.
        phase = PH_OP;
        if (b != OP_END) decode_opcode(b);
      end
    endcase
  endfunction

  // Called for every accepted input transfer; queues the results it must cause.
  function void take_byte(logic cmd, logic [7:0] data, logic loop_flag);
    int          n;
    result_rec_t r;
    step_bytes.delete();
    if (cmd == CMD_STREAM) begin
      if (loop_flag) begin
        loop_pos   = emitted;
        loop_total = total;
      end
      decode_byte(data);
      n = step_bytes.size();
    end else begin
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      r.kind          = (cmd == CMD_FINISH) ? KIND_STATUS : KIND_BYTE;
      r.data          = (cmd == CMD_FINISH) ? 8'h00 : step_bytes[k];
      r.last          = (k == n - 1);
      r.st.mute       = muted;
      r.st.total_time = total;
      r.st.loop_pos   = loop_pos;
      r.st.loop_total = loop_total;
      r.st.out_len    = emitted;
      r.st.overflow   = overflowed;
      expected_records.push_back(r);
    end
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      failures++;
    end
  endfunction

  function void compare_result(result_rec_t got);
    result_rec_t want;
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d byte %h",
               $time, got.kind, got.data);
      failures++;
      return;
    end
    want = expected_records.pop_front();
    check_field("kind", 32'(want.kind), 32'(got.kind));
    check_field("out_byte", 32'(want.data), 32'(got.data));
    check_field("last_of_run", 32'(want.last), 32'(got.last));
    check_field("mute", 32'(want.st.mute), 32'(got.st.mute));
    check_field("total_time", want.st.total_time, got.st.total_time);
    check_field("loop_start_position", 32'(want.st.loop_pos), 32'(got.st.loop_pos));
    check_field("loop_start_total", want.st.loop_total, got.st.loop_total);
    check_field("output_length", 32'(want.st.out_len), 32'(got.st.out_len));
    check_field("overflow", 32'(want.st.overflow), 32'(got.st.overflow));
  endfunction
endclass

module music_sequence_command_decoder_top_test;
  // A small buffer lets the count reach its cap within a normal run.
  localparam int BUF_BYTES     = 1024;
  localparam int COUNT_CAP     = (BUF_BYTES < 32767) ? BUF_BYTES : 32767;
  localparam int ITEM_GOAL     = 410;
  localparam int SETTLE_CYCLES = 20;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  localparam logic [7:0] PASS_ONE [8] = '{OP_PASS1_A, OP_PASS1_B, OP_PASS1_C, OP_PASS1_D,
                                          OP_PASS1_E, OP_PASS1_F, OP_PASS1_G, OP_PASS1_H};
  localparam logic [7:0] OP_UNLISTED [4] = '{8'hE2, 8'hE3, 8'hED, 8'hFB};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_stream_byte;
  logic        in_loop_block_start;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        out_mute;
  logic [31:0] out_total_time;
  logic [14:0] out_loop_start_position;
  logic [31:0] out_loop_start_total;
  logic [14:0] out_output_length;
  logic        out_overflow;

  record_scoreboard board;
  int               burst_left;
  int               items_sent;

  music_sequence_command_decoder_top #(
    .OUT_BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_command              (in_command),
    .in_stream_byte          (in_stream_byte),
    .in_loop_block_start     (in_loop_block_start),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_kind                (out_kind),
    .out_byte                (out_byte),
    .out_last_of_run         (out_last_of_run),
    .out_mute                (out_mute),
    .out_total_time          (out_total_time),
    .out_loop_start_position (out_loop_start_position),
    .out_loop_start_total    (out_loop_start_total),
    .out_output_length       (out_output_length),
    .out_overflow            (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  // A transfer happens at an edge where valid is high and stall is low; values read right
  // after the edge are still the ones the edge sampled.
  always @(posedge clk) begin
    result_rec_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_kind, out_byte, out_last_of_run, out_mute, out_total_time,
             out_loop_start_position, out_loop_start_total, out_output_length, out_overflow};
      board.compare_result(got);
    end
  end

  // The receiver switches between free running, light, heavy and periodic stalling.
  initial begin
    int mode;
    int left;
    out_stall <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 60);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((left % 5) < 2);
      endcase
    end
  end

  task automatic send_item(logic cmd, logic [7:0] data, logic loop_flag);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) idle = $urandom_range(20, 40);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_stream_byte      <= data;
    in_loop_block_start <= loop_flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(cmd, data, loop_flag);
    items_sent++;
  endtask

  // Stream byte with an occasional loop mark, sometimes preceded by a finish request.
  task automatic send_byte(logic [7:0] data);
    if ($urandom_range(0, 39) == 0) send_item(CMD_FINISH, 8'($urandom), 1'($urandom));
    send_item(CMD_STREAM, data, $urandom_range(0, 24) == 0);
  endtask

  task automatic wait_for_drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // One well-formed command with random content, or now and then a stray byte.
  task automatic send_command();
    int          pick;
    int          n;
    logic [7:0]  op;
    logic [15:0] t16;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_byte(8'($urandom_range(OP_T8_FIRST, OP_T8_LAST)));
      send_byte(8'($urandom));
    end else if (pick < 32) begin
      case ($urandom_range(0, 5))
        0: t16 = 16'($urandom_range(0, 16));
        1: t16 = 16'h8000;
        2: t16 = 16'h7FFF;
        3: t16 = 16'hFFFF - 16'($urandom_range(0, 16));
        default: t16 = 16'($urandom);
      endcase
      send_byte(8'($urandom_range(OP_T16_FIRST, OP_T16_LAST)));
      send_byte(t16[7:0]);
      send_byte(t16[15:8]);
    end else if (pick < 62) begin
      send_byte(8'($urandom_range(OP_DEF_FIRST, OP_DEF_LAST)));
    end else if (pick < 68) begin
      if ($urandom_range(0, 1) == 1) begin
        send_byte(OP_GREL);
        send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
      end else begin
        send_byte(OP_GABS);
        send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 64)));
      end
    end else if (pick < 76) begin
      case ($urandom_range(0, 5))
        0: send_byte(OP_OCT_UP);
        1: send_byte(OP_OCT_DN);
        2: send_byte(OP_NOCT_DN);
        3: send_byte(OP_NOCT_UP);
        default: begin
          send_byte(($urandom_range(0, 1) == 1) ? OP_OCTB : OP_OCTN);
          send_byte(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
        end
      endcase
    end else if (pick < 80) begin
      send_byte(OP_LEN);
      if ($urandom_range(0, 1) == 1) begin
        send_byte(8'($urandom_range(0, 127)));
      end else begin
        send_byte(8'($urandom_range(128, 255)));
        send_byte(8'($urandom));
      end
    end else if (pick < 87) begin
      case ($urandom_range(0, 5))
        0: begin
          op = OP_PASS0;
          n  = 0;
        end
        1: begin
          op = ($urandom_range(0, 1) == 1) ? OP_PASS8_A : OP_PASS8_B;
          n  = 8;
        end
        2: begin
          op = OP_PASS10;
          n  = 10;
        end
        3: begin
          op = OP_PASS3;
          n  = 3;
        end
        default: begin
          op = PASS_ONE[$urandom_range(0, 7)];
          n  = 1;
        end
      endcase
      send_byte(op);
      repeat (n) send_byte(8'($urandom));
    end else if (pick < 91) begin
      case ($urandom_range(0, 3))
        0: begin
          op = OP_SKIP2;
          n  = 2;
        end
        1: begin
          op = OP_SKIP1_A;
          n  = 1;
        end
        2: begin
          op = OP_SKIP1_B;
          n  = 1;
        end
        default: begin
          op = OP_SKIP3;
          n  = 3;
        end
      endcase
      send_byte(op);
      repeat (n) send_byte(8'($urandom));
    end else if (pick < 92) begin
      send_byte(OP_MUTE);
    end else if (pick < 95) begin
      send_byte(OP_END);
    end else if (pick < 97) begin
      // Unlisted opcodes are dropped by the decoder.
      case ($urandom_range(0, 2))
        0: op = 8'($urandom_range(OP_T16_LAST + 1, OP_DEF_FIRST - 1));
        1: op = 8'($urandom_range(OP_DEF_LAST + 1, OP_PASS1_A - 1));
        default: op = OP_UNLISTED[$urandom_range(0, 3)];
      endcase
      send_item(CMD_STREAM, op, 1'b0);
    end else begin
      // A stray byte can break the framing of whatever follows.
      send_item(CMD_STREAM, 8'($urandom), 1'b0);
    end
  endtask

  initial begin
    bit paused;
    board = new(COUNT_CAP);
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_command          <= CMD_STREAM;
    in_stream_byte      <= 8'h00;
    in_loop_block_start <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    paused     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Status right after reset.
    send_item(CMD_FINISH, 8'hA5, 1'b1);
    // Long-time rest at the most negative time.
    send_item(CMD_STREAM, OP_T16_FIRST, 1'b0);
    send_item(CMD_STREAM, 8'h00, 1'b0);
    send_item(CMD_STREAM, 8'h80, 1'b0);
    // Highest note at the largest time, with a block-end byte as operand data.
    send_item(CMD_STREAM, OP_T16_LAST, 1'b0);
    send_item(CMD_STREAM, OP_END, 1'b0);
    send_item(CMD_STREAM, 8'h7F, 1'b0);
    // Finish in the middle of a note command, then a loop mark on its operand.
    send_item(CMD_STREAM, OP_T8_LAST, 1'b0);
    send_item(CMD_FINISH, 8'h00, 1'b0);
    send_item(CMD_STREAM, 8'hFF, 1'b1);
    // Full relative gate, then an absolute gate equal to the note time.
    send_item(CMD_STREAM, OP_GREL, 1'b0);
    send_item(CMD_STREAM, 8'h07, 1'b0);
    send_item(CMD_STREAM, OP_DEF_LAST, 1'b0);
    send_item(CMD_STREAM, OP_GABS, 1'b0);
    send_item(CMD_STREAM, 8'h40, 1'b0);
    send_item(CMD_STREAM, OP_DEF_FIRST + 8'd5, 1'b0);
    // Note of time one.
    send_item(CMD_STREAM, OP_T8_FIRST + 8'd1, 1'b0);
    send_item(CMD_STREAM, 8'h01, 1'b0);
    // Longest default length in the two-byte form.
    send_item(CMD_STREAM, OP_LEN, 1'b0);
    send_item(CMD_STREAM, 8'hFF, 1'b0);
    send_item(CMD_STREAM, 8'hFF, 1'b0);
    // Out-of-range octave makes the pitch wrap.
    send_item(CMD_STREAM, OP_OCTB, 1'b0);
    send_item(CMD_STREAM, 8'hFF, 1'b0);
    send_item(CMD_STREAM, OP_DEF_FIRST + 8'd1, 1'b0);
    send_item(CMD_STREAM, OP_END, 1'b0);
    send_item(CMD_STREAM, OP_MUTE, 1'b0);
    wait_for_drain();

    while (items_sent < ITEM_GOAL) begin
      send_command();
      if (!paused && items_sent >= ITEM_GOAL / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* music_sequence_command_decoder_top.f */
+incdir+rtl/core
rtl/core/mscd_pkg.sv
rtl/core/mscd_front.sv
rtl/core/mscd_gate.sv
rtl/core/mscd_queue.sv
rtl/core/mscd_back.sv
rtl/core/music_sequence_command_decoder_top.sv
rtl/core/mscd_checker.sv
tb/music_sequence_command_decoder_top_test.sv
